// File: hdl/oad_pkg.sv
// Shared types, constants and helper functions for the oriented box anchor decoder.
`default_nettype none
package oad_pkg;

  localparam int MAX_CLASSES  = 256;
  localparam int OBJ_CAP      = 1024;
  localparam int CORDIC_STEPS = 20;
  localparam int QDEPTH       = 2;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_COEF  = 2'd1;
  localparam logic [1:0] MODE_PRED  = 2'd2;

  typedef struct packed {
    logic [8:0]  class_count;
    logic [16:0] score_threshold;
    logic [10:0] object_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bw;
    logic signed [31:0] bh;
    logic signed [31:0] angle;
    logic signed [31:0] score;
    logic [7:0]         cls;
    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic signed [31:0] mc;
    logic signed [31:0] md;
    logic signed [31:0] me;
    logic signed [31:0] mf;
  } job_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
    logic signed [31:0] box_angle;
    logic signed [31:0] confidence;
    logic [7:0]         label;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Truncated arctangent table in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/oriented_box_anchor_decoder.sv
// Top level: configuration registers, front end, job queue and decode engine.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------------
//  in       | input     | in_valid_i / in_ready_o  | mode_i, coef_index_i, value_i
//  out      | output    | out_valid_o / out_ready_i| center_x_o .. label_o
//  cfg      | input     | psel/penable/pwrite      | paddr, pwdata, prdata (pready tied high)
//
// The front end takes one beat per cycle while the two-entry job queue has room.
// Each kept anchor holds the decode engine until its result is registered (a saturated edge
// skips its square root): one shared 34x34 multiplier, 20 CORDIC iterations and two
// 32-step square roots.
// Reset clears all control state and the row, argmax, matrix and count registers.
// A stalled output holds its beat; the engine waits, then the queue fills and in_ready_o drops.
`default_nettype none
module oriented_box_anchor_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [2:0]  coef_index_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      center_x_o,
  output logic [31:0]      center_y_o,
  output logic [30:0]      box_width_o,
  output logic [30:0]      box_height_o,
  output logic [31:0]      box_angle_o,
  output logic [31:0]      confidence_o,
  output logic [7:0]       label_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import oad_pkg::*;

  localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_OBJ_LIMIT   = 2'd2;

  cfg_t  cfg_q;
  logic  push, q_full, q_valid, pop;
  job_t  job_in, job_out;
  res_t  res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_count     <= 9'd1;
      cfg_q.score_threshold <= '0;
      cfg_q.object_limit    <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CLASS_COUNT: cfg_q.class_count     <= pwdata[8:0];
        REG_THRESHOLD:   cfg_q.score_threshold <= pwdata[16:0];
        REG_OBJ_LIMIT:   cfg_q.object_limit    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CLASS_COUNT: prdata = {23'd0, cfg_q.class_count};
      REG_THRESHOLD:   prdata = {15'd0, cfg_q.score_threshold};
      REG_OBJ_LIMIT:   prdata = {21'd0, cfg_q.object_limit};
      default:         prdata = '0;
    endcase
  end

  oad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .coef_index_i (coef_index_i),
    .value_i      (value_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  oad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  oad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign center_x_o   = res.center_x;
  assign center_y_o   = res.center_y;
  assign box_width_o  = res.box_width;
  assign box_height_o = res.box_height;
  assign box_angle_o  = res.box_angle;
  assign confidence_o = res.confidence;
  assign label_o      = res.label;

endmodule
`default_nettype wire

// File: hdl/oad_front.sv
// Front end: takes input beats, tracks rows, argmax, threshold and object cap.
`default_nettype none
module oad_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire oad_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    mode_i,
  input  wire logic [2:0]    coef_index_i,
  input  wire logic [31:0]   value_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output oad_pkg::job_t      job_o
);
  import oad_pkg::*;

  logic [8:0]             row_q;
  logic signed [31:0]     best_q;
  logic [7:0]             cls_q;
  logic [10:0]            emit_q;
  logic [3:0][31:0]       box_q;
  logic [5:0][31:0]       mat_q;

  logic                   acc;
  logic [8:0]             cc;
  logic [10:0]            lim;
  logic                   in_box, in_cls, kept;
  logic signed [31:0]     v;

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;
  assign v = $signed(value_i);

  always_comb begin
    if (cfg_i.class_count == 9'd0) cc = 9'd1;
    else if (cfg_i.class_count > 9'(MAX_CLASSES)) cc = 9'(MAX_CLASSES);
    else cc = cfg_i.class_count;
    if (cfg_i.object_limit > 11'(OBJ_CAP)) lim = 11'(OBJ_CAP);
    else lim = cfg_i.object_limit;
  end

  assign in_box = row_q < 9'd4;
  assign in_cls = {1'b0, row_q} < (10'd4 + {1'b0, cc});
  assign kept = !(best_q < $signed({16'd0, cfg_i.score_threshold})) && (emit_q < lim);
  assign push_o = acc && (mode_i == MODE_PRED) && !in_box && !in_cls && kept;

  always_comb begin
    job_o.bx    = $signed(box_q[0]);
    job_o.by    = $signed(box_q[1]);
    job_o.bw    = $signed(box_q[2]);
    job_o.bh    = $signed(box_q[3]);
    job_o.angle = v;
    job_o.score = best_q;
    job_o.cls   = cls_q;
    job_o.ma    = $signed(mat_q[0]);
    job_o.mb    = $signed(mat_q[1]);
    job_o.mc    = $signed(mat_q[2]);
    job_o.md    = $signed(mat_q[3]);
    job_o.me    = $signed(mat_q[4]);
    job_o.mf    = $signed(mat_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      best_q <= '0;
      cls_q  <= '0;
      emit_q <= '0;
      box_q  <= '0;
      mat_q  <= '0;
    end else if (acc) begin
      case (mode_i)
        MODE_START: begin
          row_q  <= '0;
          best_q <= '0;
          cls_q  <= '0;
          emit_q <= '0;
        end
        MODE_COEF: begin
          if (coef_index_i < 3'd6) mat_q[coef_index_i] <= value_i;
        end
        MODE_PRED: begin
          if (in_box) begin
            box_q[row_q[1:0]] <= value_i;
            row_q <= row_q + 9'd1;
          end else if (in_cls) begin
            if (row_q == 9'd4 || v > best_q) begin
              best_q <= v;
              cls_q  <= 8'(row_q - 9'd4);
            end
            row_q <= row_q + 9'd1;
          end else begin
            // angle slot closes the row
            row_q <= '0;
            if (kept) emit_q <= emit_q + 11'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/oad_queue.sv
// Short job queue between the front end and the decode engine.
`default_nettype none
module oad_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire oad_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output oad_pkg::job_t      data_o
);
  import oad_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem_q [QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("queue pop while empty");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !full_o) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count did not advance");

endmodule
`default_nettype wire

// File: hdl/oad_back.sv
// Decode engine: affine projection, CORDIC, edge lengths, square root, output register.
`default_nettype none
module oad_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire oad_pkg::job_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output oad_pkg::res_t      res_o
);
  import oad_pkg::*;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_CTR  = 4'd1;
  localparam logic [3:0] B_PH   = 4'd2;
  localparam logic [3:0] B_ZM   = 4'd3;
  localparam logic [3:0] B_COR  = 4'd4;
  localparam logic [3:0] B_EDG  = 4'd5;
  localparam logic [3:0] B_LIN  = 4'd6;
  localparam logic [3:0] B_SQ   = 4'd7;
  localparam logic [3:0] B_SQRT = 4'd8;
  localparam logic [3:0] B_OUT  = 4'd9;

  localparam logic signed [49:0] LMAX = 50'sd2147483647;

  logic [3:0]          st_q;
  logic [1:0]          step_q;
  logic                sub_q, edge_q, neg_q;
  logic [4:0]          cnt_q;
  job_t                job_q;
  logic signed [67:0]  prod_q;
  logic signed [49:0]  acc_q, lx_q;
  logic signed [31:0]  cx_q, cy_q;
  logic signed [33:0]  z_q, x_q, y_q;
  logic signed [33:0]  exw_q, eyw_q, exh_q, eyh_q;
  logic [63:0]         sum_q, n_q, r_q;
  logic [30:0]         wid_q, hgt_q;
  logic                out_valid_q;
  res_t                res_q;

  logic signed [33:0]  mul_a, mul_b, c_val, s_val, ex, ey;
  logic signed [67:0]  sh16, sh30, nsh30;
  logic signed [49:0]  lin_sum;
  logic signed [31:0]  zph;
  logic signed [33:0]  dx, dy, at;
  logic [63:0]         bitv, trial, r_nx, n_nx;
  logic [30:0]         sq_res;
  logic                out_free;

  function automatic logic signed [33:0] ext34(input logic signed [31:0] a);
    return {{2{a[31]}}, a};
  endfunction

  assign c_val = neg_q ? -x_q : x_q;
  assign s_val = neg_q ? -y_q : y_q;
  assign ex    = edge_q ? exh_q : exw_q;
  assign ey    = edge_q ? eyh_q : eyw_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      B_CTR: begin
        case (step_q)
          2'd0:    begin mul_a = ext34(job_q.ma); mul_b = ext34(job_q.bx); end
          2'd1:    begin mul_a = ext34(job_q.mb); mul_b = ext34(job_q.by); end
          2'd2:    begin mul_a = ext34(job_q.md); mul_b = ext34(job_q.bx); end
          default: begin mul_a = ext34(job_q.me); mul_b = ext34(job_q.by); end
        endcase
      end
      B_PH: begin mul_a = ext34(job_q.angle); mul_b = 34'sd683565276; end
      B_ZM: begin mul_a = z_q; mul_b = 34'sd3373259426; end
      B_EDG: begin
        case (step_q)
          2'd0:    begin mul_a = ext34(job_q.bw); mul_b = c_val; end
          2'd1:    begin mul_a = ext34(job_q.bw); mul_b = s_val; end
          2'd2:    begin mul_a = ext34(job_q.bh); mul_b = s_val; end
          default: begin mul_a = ext34(job_q.bh); mul_b = c_val; end
        endcase
      end
      B_LIN: begin
        case (step_q)
          2'd0:    begin mul_a = ext34(job_q.ma); mul_b = ex; end
          2'd1:    begin mul_a = ext34(job_q.mb); mul_b = ey; end
          2'd2:    begin mul_a = ext34(job_q.md); mul_b = ex; end
          default: begin mul_a = ext34(job_q.me); mul_b = ey; end
        endcase
      end
      B_SQ: begin
        if (step_q == 2'd0) begin mul_a = lx_q[33:0]; mul_b = lx_q[33:0]; end
        else begin mul_a = acc_q[33:0]; mul_b = acc_q[33:0]; end
      end
      default: ;
    endcase
  end

  assign sh16    = prod_q >>> 16;
  assign sh30    = prod_q >>> 30;
  assign nsh30   = (-prod_q) >>> 30;
  assign lin_sum = acc_q + $signed(sh16[49:0]);
  assign zph     = $signed(sh16[31:0]);

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = $signed({4'd0, atan_q30(cnt_q)});

  assign bitv  = 64'd1 << (6'd62 - {cnt_q, 1'b0});
  assign trial = r_q + bitv;
  assign n_nx  = (n_q >= trial) ? n_q - trial : n_q;
  assign r_nx  = (n_q >= trial) ? (r_q >> 1) + bitv : r_q >> 1;
  assign sq_res = (r_nx > 64'h7FFFFFFF) ? 31'h7FFFFFFF : r_nx[30:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (st_q == B_IDLE) && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= q_data_i;
    if (!sub_q) prod_q <= mul_a * mul_b;
    if (st_q == B_OUT && out_free) begin
      res_q.center_x   <= cx_q;
      res_q.center_y   <= cy_q;
      res_q.box_width  <= wid_q;
      res_q.box_height <= hgt_q;
      res_q.box_angle  <= job_q.angle;
      res_q.confidence <= job_q.score;
      res_q.label      <= job_q.cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      step_q      <= '0;
      sub_q       <= 1'b0;
      cnt_q       <= '0;
      edge_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && st_q != B_OUT) out_valid_q <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (q_valid_i) begin
            st_q   <= B_CTR;
            step_q <= '0;
            sub_q  <= 1'b0;
          end
        end
        B_COR: begin
          if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
            st_q   <= B_EDG;
            step_q <= '0;
            sub_q  <= 1'b0;
          end
          cnt_q <= cnt_q + 5'd1;
        end
        B_SQRT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            if (!edge_q) begin
              edge_q <= 1'b1;
              st_q   <= B_LIN;
              step_q <= '0;
            end else begin
              st_q <= B_OUT;
            end
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            st_q        <= B_IDLE;
          end
        end
        default: begin
          // multiplier states: issue the product, then use it once it is registered
          sub_q <= !sub_q;
          if (sub_q) begin
            case (st_q)
              B_CTR: begin
                if (step_q == 2'd3) begin
                  st_q   <= B_PH;
                  step_q <= '0;
                end else begin
                  step_q <= step_q + 2'd1;
                end
              end
              B_PH: st_q <= B_ZM;
              B_ZM: begin st_q <= B_COR; cnt_q <= '0; end
              B_EDG: begin
                if (step_q == 2'd3) begin
                  st_q   <= B_LIN;
                  step_q <= '0;
                  edge_q <= 1'b0;
                end else begin
                  step_q <= step_q + 2'd1;
                end
              end
              B_LIN: begin
                if (step_q == 2'd3) begin
                  step_q <= '0;
                  if (lx_q > LMAX || lx_q < -LMAX || lin_sum > LMAX || lin_sum < -LMAX) begin
                    // edge too large: length saturates
                    if (!edge_q) edge_q <= 1'b1;
                    else st_q <= B_OUT;
                  end else begin
                    st_q <= B_SQ;
                  end
                end else begin
                  step_q <= step_q + 2'd1;
                end
              end
              B_SQ: begin
                if (step_q == 2'd1) begin
                  st_q  <= B_SQRT;
                  cnt_q <= '0;
                end else begin
                  step_q <= step_q + 2'd1;
                end
              end
              default: st_q <= B_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      B_CTR: if (sub_q) begin
        case (step_q)
          2'd0:    acc_q <= $signed(sh16[49:0]);
          2'd1:    cx_q  <= sat32(lin_sum + {{18{job_q.mc[31]}}, job_q.mc});
          2'd2:    acc_q <= $signed(sh16[49:0]);
          default: cy_q  <= sat32(lin_sum + {{18{job_q.mf[31]}}, job_q.mf});
        endcase
      end
      B_PH: if (sub_q) begin
        if (zph > 32'sd1073741824) begin
          z_q <= ext34(zph - 32'sh80000000);
          neg_q <= 1'b1;
        end else if (zph < -32'sd1073741824) begin
          z_q <= ext34(zph + 32'sh80000000);
          neg_q <= 1'b1;
        end else begin
          z_q <= ext34(zph);
          neg_q <= 1'b0;
        end
      end
      B_ZM: if (sub_q) begin
        z_q <= $signed(prod_q[64:31]);
        x_q <= 34'sd652032874;
        y_q <= '0;
      end
      B_COR: begin
        if (!z_q[33]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
      end
      B_EDG: if (sub_q) begin
        case (step_q)
          2'd0:    exw_q <= sh30[33:0];
          2'd1:    eyw_q <= sh30[33:0];
          2'd2:    exh_q <= nsh30[33:0];
          default: eyh_q <= sh30[33:0];
        endcase
      end
      B_LIN: if (sub_q) begin
        case (step_q)
          2'd0:    acc_q <= $signed(sh16[49:0]);
          2'd1:    lx_q  <= lin_sum;
          2'd2:    acc_q <= $signed(sh16[49:0]);
          default: begin
            acc_q <= lin_sum;
            if (lx_q > LMAX || lx_q < -LMAX || lin_sum > LMAX || lin_sum < -LMAX) begin
              if (!edge_q) wid_q <= 31'h7FFFFFFF;
              else hgt_q <= 31'h7FFFFFFF;
            end
          end
        endcase
      end
      B_SQ: if (sub_q) begin
        if (step_q == 2'd0) sum_q <= prod_q[63:0];
        else begin
          n_q <= sum_q + prod_q[63:0];
          r_q <= '0;
        end
      end
      B_SQRT: begin
        n_q <= n_nx;
        r_q <= r_nx;
        if (cnt_q == 5'd31) begin
          if (!edge_q) wid_q <= sq_res;
          else hgt_q <= sq_res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: test/tb_oriented_box_anchor_decoder.sv
// Testbench for the oriented box anchor decoder: directed and random rows against a local model.
`default_nettype none
module tb_oriented_box_anchor_decoder;
  import oad_pkg::*;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  SETTLE       = 400;
  localparam int  ADDR_CLASSES = 0;
  localparam int  ADDR_THRESH  = 4;
  localparam int  ADDR_LIMIT   = 8;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam longint ATAN_TAB [20] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047};

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  cidx;
    logic [31:0] value;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [2:0]  coef_index_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] center_x_o, center_y_o, box_angle_o, confidence_o;
  logic [30:0] box_width_o, box_height_o;
  logic [7:0]  label_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  oriented_box_anchor_decoder dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .coef_index_i, .value_i,
    .out_valid_o, .out_ready_i, .center_x_o, .center_y_o, .box_width_o, .box_height_o,
    .box_angle_o, .confidence_o, .label_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // decoder model state
  int unsigned n_classes = 1, thresh = 0, obj_limit = 1024;
  int unsigned slot = 0, best_idx = 0, kept = 0;
  longint      best_val = 0;
  longint      geom [4] = '{default: 0};
  longint      mat [6] = '{default: 0};

  beat_t  beat_queue [$];
  res_t   box_queue [$];
  int     mismatches = 0;
  int     accepted = 0;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint affine_lin(longint p, longint q, longint x, longint y);
    return ((p * x) >>> 16) + ((q * y) >>> 16);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic rotate(input longint ang, output longint cv, output longint sv);
    logic [31:0] ph;
    longint      z, x, y, dx, dy, t;
    bit          flip;
    t = (ang * 64'sd683565276) >>> 16;
    ph = t[31:0];
    z = longint'($signed(ph));
    flip = 1'b0;
    x = 652032874;
    y = 0;
    // fold past a quarter turn
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648;
      flip = 1'b1;
    end
    z = (z * 64'sd3373259426) >>> 31;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    cv = flip ? -x : x;
    sv = flip ? -y : y;
  endtask

  function automatic logic [30:0] edge_length(longint ex, longint ey);
    longint lx, ly;
    longint unsigned r;
    lx = affine_lin(mat[0], mat[1], ex, ey);
    ly = affine_lin(mat[3], mat[4], ex, ey);
    if (lx >= 64'sd2147483648 || lx <= -64'sd2147483648 ||
        ly >= 64'sd2147483648 || ly <= -64'sd2147483648)
      return 31'h7FFFFFFF;
    r = root_floor(longint'(lx * lx) + longint'(ly * ly));
    return (r > 64'h7FFFFFFF) ? 31'h7FFFFFFF : r[30:0];
  endfunction

  task automatic decode_beat(input beat_t b);
    longint      v, cx, cy, cv, sv, w, h;
    int unsigned cc, lim;
    res_t        r;
    v = longint'($signed(b.value));
    case (b.mode)
      MODE_START: begin
        slot = 0;
        best_val = 0;
        best_idx = 0;
        kept = 0;
      end
      MODE_COEF: if (b.cidx < 6) mat[b.cidx] = v;
      MODE_PRED: begin
        cc = (n_classes == 0) ? 1 : n_classes;
        if (cc > MAX_CLASSES) cc = MAX_CLASSES;
        if (slot < 4) begin
          geom[slot] = v;
          slot++;
        end else if (slot < 4 + cc) begin
          if (slot == 4 || v > best_val) begin
            best_val = v;
            best_idx = slot - 4;
          end
          slot++;
        end else begin
          slot = 0;
          lim = (obj_limit > OBJ_CAP) ? OBJ_CAP : obj_limit;
          if (best_val >= longint'(thresh) && kept < lim) begin
            kept++;
            cx = sat_word(affine_lin(mat[0], mat[1], geom[0], geom[1]) + mat[2]);
            cy = sat_word(affine_lin(mat[3], mat[4], geom[0], geom[1]) + mat[5]);
            rotate(v, cv, sv);
            w = geom[2];
            h = geom[3];
            r.center_x   = cx[31:0];
            r.center_y   = cy[31:0];
            r.box_width  = edge_length((w * cv) >>> 30, (w * sv) >>> 30);
            r.box_height = edge_length((-(h * sv)) >>> 30, (h * cv) >>> 30);
            r.box_angle  = b.value;
            r.confidence = best_val[31:0];
            r.label      = best_idx[7:0];
            box_queue.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // sender: bursts with random gaps
  beat_t cur_beat;
  int    burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_beat(cur_beat);
        accepted++;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (beat_queue.size() > 0) begin
        cur_beat = beat_queue.pop_front();
        in_valid_i   <= 1'b1;
        mode_i       <= cur_beat.mode;
        coef_index_i <= cur_beat.cidx;
        value_i      <= cur_beat.value;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int  hold_left = 0, style = 0, style_left = 0;
  bit  held_once = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (style_left == 0) begin
        style = $urandom_range(0, 2);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held_once && accepted > 500) begin
        held_once = 1'b1;
        hold_left = 3000;
        out_ready_i <= 1'b0;
      end else begin
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  // output check
  res_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{center_x_o, center_y_o, box_width_o, box_height_o, box_angle_o,
              confidence_o, label_o};
      if (box_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected box beat: %p", got);
      end else begin
        want = box_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("box mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push(input logic [1:0] m, input logic [2:0] ci, input logic [31:0] v);
    beat_t b;
    b.mode = m;
    b.cidx = ci;
    b.value = v;
    beat_queue.push_back(b);
  endtask

  task automatic wait_idle();
    while (beat_queue.size() != 0 || in_valid_i || box_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input int addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr[3:0];
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_CLASSES: n_classes = data & 32'h1FF;
      ADDR_THRESH:  thresh = data & 32'h1FFFF;
      default:      obj_limit = data & 32'h7FF;
    endcase
  endtask

  function automatic logic [31:0] rnd_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 262144) - 131072;
  endfunction

  task automatic push_matrix();
    push(MODE_COEF, 3'd0, rnd_coef());
    push(MODE_COEF, 3'd1, $urandom_range(0, 65536) - 32768);
    push(MODE_COEF, 3'd2, $urandom_range(0, 32'h4000000) - 32'h2000000);
    push(MODE_COEF, 3'd3, $urandom_range(0, 65536) - 32768);
    push(MODE_COEF, 3'd4, rnd_coef());
    push(MODE_COEF, 3'd5, $urandom);
    push(MODE_COEF, 3'($urandom_range(6, 7)), $urandom);
  endtask

  task automatic push_row(input int cc);
    logic [31:0] s;
    push(MODE_PRED, 3'($urandom), ($urandom_range(0, 7) == 0) ? $urandom :
         $urandom_range(0, 32'h8000000) - 32'h4000000);
    push(MODE_PRED, 3'($urandom), ($urandom_range(0, 7) == 0) ? $urandom :
         $urandom_range(0, 32'h8000000) - 32'h4000000);
    push(MODE_PRED, 3'($urandom), ($urandom_range(0, 7) == 0) ? $urandom :
         $urandom_range(0, 32'h2000000));
    push(MODE_PRED, 3'($urandom), ($urandom_range(0, 7) == 0) ? $urandom :
         $urandom_range(0, 32'h2000000));
    for (int i = 0; i < cc; i++) begin
      case ($urandom_range(0, 3))
        0: s = $urandom;
        1: s = thresh;
        default: s = thresh + $urandom_range(0, 40000) - 20000;
      endcase
      push(MODE_PRED, 3'($urandom), s);
      if ($urandom_range(0, 40) == 0) push(MODE_NONE, 3'($urandom), $urandom);
    end
    push(MODE_PRED, 3'($urandom), $urandom);
  endtask

  int phase_cc, made;
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero matrix, one class
    push(MODE_PRED, 3'd0, 32'h7FFFFFFF);
    push(MODE_PRED, 3'd0, 32'h80000000);
    push(MODE_PRED, 3'd0, 32'h00010000);
    push(MODE_PRED, 3'd0, 32'h00020000);
    push(MODE_PRED, 3'd0, 32'h0000C000);
    push(MODE_PRED, 3'd0, 32'h00000000);
    push(MODE_START, 3'd7, 32'hFFFFFFFF);
    // identity map, then tied scores and angle extremes
    push(MODE_COEF, 3'd0, 32'h00010000);
    push(MODE_COEF, 3'd4, 32'h00010000);
    push(MODE_COEF, 3'd6, 32'h12345678);
    push(MODE_NONE, 3'd0, 32'h00010000);
    wait_idle();
    reg_write(ADDR_CLASSES, 3);
    reg_write(ADDR_THRESH, 32'h8000);
    foreach (ATAN_TAB[i]) if (i < 3) begin
      push(MODE_PRED, 3'd0, 32'h00050000);
      push(MODE_PRED, 3'd0, 32'hFFFB0000);
      push(MODE_PRED, 3'd0, 32'h00040000);
      push(MODE_PRED, 3'd0, 32'h00020000);
      push(MODE_PRED, 3'd0, 32'h00009000);
      push(MODE_PRED, 3'd0, 32'h00009000);
      push(MODE_PRED, 3'd0, (i == 2) ? 32'h00007FFF : 32'h00009000);
      push(MODE_PRED, 3'd0, (i == 0) ? 32'h0003243F : (i == 1) ? 32'hFFFCDBC1 : 32'h7FFFFFFF);
    end
    wait_idle();
    // mid-row shrink of the class count: the next value lands in the angle slot
    push(MODE_START, 3'd0, 32'd0);
    for (int i = 0; i < 6; i++) push(MODE_PRED, 3'd0, 32'h00010000 * i);
    wait_idle();
    reg_write(ADDR_CLASSES, 1);
    push(MODE_PRED, 3'd0, 32'h00001000);

    made = 0;
    while (made < 1450) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: phase_cc = 0;
        1: phase_cc = (made > 700 && made < 1000) ? 256 : 2;
        2: phase_cc = (made < 700) ? 300 : 5;
        default: phase_cc = $urandom_range(1, 6);
      endcase
      reg_write(ADDR_CLASSES, phase_cc);
      reg_write(ADDR_THRESH, ($urandom_range(0, 3) == 0) ? 65536 :
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65536));
      case ($urandom_range(0, 5))
        0: reg_write(ADDR_LIMIT, 0);
        1: reg_write(ADDR_LIMIT, 1);
        2: reg_write(ADDR_LIMIT, 2047);
        3: reg_write(ADDR_LIMIT, 1024);
        default: reg_write(ADDR_LIMIT, $urandom_range(2, 20));
      endcase
      if (phase_cc == 0) phase_cc = 1;
      if (phase_cc > MAX_CLASSES) phase_cc = MAX_CLASSES;
      for (int img = 0; img < 3; img++) begin
        push(MODE_START, 3'($urandom), $urandom);
        if ($urandom_range(0, 2) != 0) push_matrix();
        for (int r = 0; r < ((phase_cc > 50) ? 1 : $urandom_range(3, 10)); r++) begin
          push_row(phase_cc);
          made += phase_cc + 5;
        end
      end
      // a stray partial row now and then carries across the next settings change
      if ($urandom_range(0, 3) == 0) push(MODE_PRED, 3'($urandom), $urandom);
    end

    wait_idle();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
